>>> hdl/ffba_pkg.sv
package ffba_pkg;

    localparam int POOL_BYTES    = 65536;
    localparam int GRANULE_BYTES = 8;
    localparam int HEADER_BYTES  = 24;

    localparam int ENTRY_COUNT = POOL_BYTES / GRANULE_BYTES;
    localparam int GRAN_SHIFT  = $clog2(GRANULE_BYTES);
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int SIZE_W      = IDX_W + 1;

    localparam int REQ_W = 17;
    localparam int OFF_W = 16;
    localparam int ST_W  = 3;

    // Smallest block in granules: header plus one granule, rounded up.
    localparam int MIN_G  = (HEADER_BYTES + 2 * GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int SUM_W  = REQ_W + 1;
    localparam int NEED_W = SUM_W - GRAN_SHIFT;
    localparam int CMP_W  = ((SIZE_W > NEED_W) ? SIZE_W : NEED_W) + 1;
    localparam int POOL_LOG = $clog2(POOL_BYTES);
    localparam int PW = ((POOL_LOG > OFF_W) ? POOL_LOG : OFF_W) + 1;
    localparam int GW = (((IDX_W + GRAN_SHIFT) > OFF_W) ? (IDX_W + GRAN_SHIFT) : OFF_W) + 1;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOFIT   = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              is_free;
        logic              link_ok;
        logic [IDX_W-1:0]  link;
    } entry_t;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_CUR  = 3'd1,
        WR_TAIL = 3'd2,
        WR_PREV = 3'd3,
        WR_FREE = 3'd4
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_cur;
        logic    rd_idx;
        logic    step;
        logic    take;
        wr_sel_t wr;
        logic    head_alloc;
        logic    resp_load;
        status_t resp_st;
        logic    resp_grant;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic zero_req;
        logic outside;
        logic head_ok;
        logic fit;
        logic split;
        logic walk_more;
        logic rd_free;
        logic prev_ok;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/ffba_ctrl.sv
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_A_EVAL  = 8'b0000_0100,
        S_A_WCUR  = 8'b0000_1000,
        S_A_WTAIL = 8'b0001_0000,
        S_A_WPREV = 8'b0010_0000,
        S_F_EVAL  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    grant_reg, grant_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            grant_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            grant_reg <= grant_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        grant_next     = grant_reg;
        cmd            = '0;
        cmd.wr         = WR_NONE;
        cmd.resp_st    = st_reg;
        cmd.resp_grant = grant_reg;
        in_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    grant_next = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op_free)
                begin
                    if (stat.outside)
                    begin
                        st_next    = ST_OUTSIDE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_idx = 1'b1;
                        state_next = S_F_EVAL;
                    end
                end
                else if (stat.zero_req)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_RESP;
                end
                else if (!stat.head_ok)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL:
            begin
                if (stat.fit)
                begin
                    cmd.take   = 1'b1;
                    st_next    = ST_OK;
                    grant_next = 1'b1;
                    state_next = S_A_WCUR;
                end
                else if (stat.walk_more)
                begin
                    // The next header is read in the same cycle the walk advances.
                    cmd.step = 1'b1;
                end
                else
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_RESP;
                end
            end
            S_A_WCUR:
            begin
                cmd.wr         = WR_CUR;
                cmd.head_alloc = !stat.prev_ok;
                if (stat.split)
                    state_next = S_A_WTAIL;
                else if (stat.prev_ok)
                    state_next = S_A_WPREV;
                else
                    state_next = S_RESP;
            end
            S_A_WTAIL:
            begin
                cmd.wr = WR_TAIL;
                if (stat.prev_ok)
                    state_next = S_A_WPREV;
                else
                    state_next = S_RESP;
            end
            S_A_WPREV:
            begin
                cmd.wr     = WR_PREV;
                state_next = S_RESP;
            end
            S_F_EVAL:
            begin
                if (stat.rd_free)
                    st_next = ST_ALREADY;
                else
                begin
                    cmd.wr  = WR_FREE;
                    st_next = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ffba_dpath.sv
module ffba_dpath
    import ffba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             operation,
    input  logic [REQ_W-1:0] request_bytes,
    input  logic [OFF_W-1:0] release_offset,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ST_W-1:0]  status,
    output logic [OFF_W-1:0] granted_offset,
    input  cmd_t             cmd,
    output stat_t            stat
);

    localparam entry_t ENTRY0_RESET = '{size: SIZE_W'(ENTRY_COUNT), is_free: 1'b1,
                                        link_ok: 1'b0, link: '0};

    entry_t mem [ENTRY_COUNT];
    entry_t mem_q;
    logic [IDX_W-1:0] rd_addr_reg;

    logic             op_reg;
    logic [REQ_W-1:0] req_reg;
    logic [OFF_W-1:0] off_reg;

    logic [IDX_W-1:0] cur_reg, prev_reg, head_reg, cnt_reg;
    logic             prev_ok_reg, head_ok_reg, split_reg, init0_reg;
    entry_t           ent_reg, prev_ent_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [OFF_W-1:0]  granted_reg;

    entry_t            rd_entry;
    logic [SUM_W-1:0]  need_sum;
    logic [NEED_W-1:0] need_raw, need_g;
    logic [CMP_W-1:0]  size_c, need_c;
    logic              fit, split;
    logic [IDX_W-1:0]  tail_idx, repl;
    logic              repl_ok;
    logic [PW-1:0]     off_w, hdr_w;
    logic              outside;
    logic [IDX_W-1:0]  free_idx;
    logic [GW-1:0]     grant_w;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t           wr_data;

    // Entry 0 holds the whole pool until it is first written.
    assign rd_entry = (init0_reg && rd_addr_reg == '0) ? ENTRY0_RESET : mem_q;

    assign need_sum = SUM_W'(req_reg) + SUM_W'(HEADER_BYTES + GRANULE_BYTES - 1);
    assign need_raw = need_sum[SUM_W-1:GRAN_SHIFT];
    assign need_g   = (need_raw < NEED_W'(MIN_G)) ? NEED_W'(MIN_G) : need_raw;

    assign size_c = CMP_W'(rd_entry.size);
    assign need_c = CMP_W'(need_g);
    assign fit    = rd_entry.is_free && (size_c >= need_c);
    assign split  = size_c >= (need_c + CMP_W'(MIN_G));

    assign tail_idx = cur_reg + IDX_W'(need_g);
    assign repl     = split_reg ? tail_idx : ent_reg.link;
    assign repl_ok  = split_reg | ent_reg.link_ok;

    assign off_w    = PW'(off_reg);
    assign hdr_w    = off_w - PW'(HEADER_BYTES);
    assign outside  = (off_w < PW'(HEADER_BYTES)) || (hdr_w >= PW'(POOL_BYTES))
                      || (hdr_w[GRAN_SHIFT-1:0] != '0);
    assign free_idx = hdr_w[GRAN_SHIFT +: IDX_W];

    assign grant_w = GW'({cur_reg, {GRAN_SHIFT{1'b0}}}) + GW'(HEADER_BYTES);

    assign rd_en   = cmd.rd_cur | cmd.rd_idx | cmd.step;
    assign rd_addr = cmd.step ? rd_entry.link : (cmd.rd_idx ? free_idx : cur_reg);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cur_reg;
        wr_data = '0;
        case (cmd.wr)
            WR_CUR:
            begin
                wr_addr      = cur_reg;
                wr_data.size = split_reg ? SIZE_W'(need_g) : ent_reg.size;
            end
            WR_TAIL:
            begin
                wr_addr         = tail_idx;
                wr_data.size    = ent_reg.size - SIZE_W'(need_g);
                wr_data.is_free = 1'b1;
                wr_data.link_ok = ent_reg.link_ok;
                wr_data.link    = ent_reg.link;
            end
            WR_PREV:
            begin
                wr_addr         = prev_reg;
                wr_data.size    = prev_ent_reg.size;
                wr_data.is_free = prev_ent_reg.is_free;
                wr_data.link_ok = repl_ok;
                wr_data.link    = repl;
            end
            WR_FREE:
            begin
                wr_addr         = free_idx;
                wr_data.size    = rd_entry.size;
                wr_data.is_free = 1'b1;
                wr_data.link_ok = head_ok_reg;
                wr_data.link    = head_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            req_reg <= request_bytes;
            off_reg <= release_offset;
            cur_reg <= head_reg;
        end
        if (cmd.step)
        begin
            prev_reg     <= cur_reg;
            prev_ent_reg <= rd_entry;
            cur_reg      <= rd_entry.link;
        end
        if (cmd.take)
        begin
            ent_reg   <= rd_entry;
            split_reg <= split;
        end
        if (cmd.resp_load)
        begin
            status_reg  <= cmd.resp_st;
            granted_reg <= cmd.resp_grant ? grant_w[OFF_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ok_reg   <= 1'b0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            head_ok_reg   <= 1'b1;
            init0_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_ok_reg <= 1'b0;
                cnt_reg     <= '0;
            end
            else if (cmd.step)
            begin
                prev_ok_reg <= 1'b1;
                cnt_reg     <= cnt_reg + 1'b1;
            end
            if (cmd.head_alloc)
            begin
                head_reg    <= repl;
                head_ok_reg <= repl_ok;
            end
            else if (cmd.wr == WR_FREE)
            begin
                head_reg    <= free_idx;
                head_ok_reg <= 1'b1;
            end
            if (wr_en && wr_addr == '0)
                init0_reg <= 1'b0;
            if (cmd.resp_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.op_free   = op_reg;
    assign stat.zero_req  = (req_reg == '0);
    assign stat.outside   = outside;
    assign stat.head_ok   = head_ok_reg;
    assign stat.fit       = fit;
    assign stat.split     = split_reg;
    assign stat.walk_more = rd_entry.link_ok && (cnt_reg != IDX_W'(ENTRY_COUNT - 1));
    assign stat.rd_free   = rd_entry.is_free;
    assign stat.prev_ok   = prev_ok_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;

endmodule

>>> hdl/first_fit_block_allocator.sv
// Allocate: decode, walk free headers from the list head (one read each) until a block fits,
// then write its header, the split tail and the predecessor link where needed. A failed walk,
// a zero-size request or an empty free list writes nothing. Free: read the header at the offset
// and push it on the free list unless already free; an offset outside the pool is not read. One
// transaction is in work at a time; input is taken again in the cycle after the result is loaded.
// Reset (rst_n, asynchronous, active low) makes the whole pool one free block at once.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             operation,
    input  logic [REQ_W-1:0] request_bytes,
    input  logic [OFF_W-1:0] release_offset,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ST_W-1:0]  status,
    output logic [OFF_W-1:0] granted_offset
);

    cmd_t  cmd;
    stat_t stat;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .operation      (operation),
        .request_bytes  (request_bytes),
        .release_offset (release_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

>>> hdl/ffba_checker.sv
module ffba_checker
    import ffba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [ST_W-1:0]  status,
    input logic [OFF_W-1:0] granted_offset
);

    logic [1:0] pending_reg, pending_next;

    // Transactions accepted whose results have not yet been taken.
    always_comb
    begin
        pending_next = pending_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
            pending_next = pending_reg + 2'd1;
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_offset))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_offset == '0)
        else $error("failed transaction carries an offset");

    a_pending_max: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many transactions in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted transaction");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_offset (granted_offset)
);
